// ----- hw/rtl/imf_pkg.sv -----
// ----------------------------------------------------------------------------
// imf_pkg: shared types and constants for the ising metropolis flip engine
// item layouts, configuration view, evaluation result and controller states
// ----------------------------------------------------------------------------
package imf_pkg;

    // opcodes of an input item
    localparam logic OP_FLIP = 1'b0;
    localparam logic OP_INIT = 1'b1;

    // register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_TH16    = 2'd0;
    localparam logic [1:0] REG_TH8     = 2'd1;
    localparam logic [1:0] REG_PATTERN = 2'd2;

    // start patterns
    localparam logic PAT_ALL_UP = 1'b0;
    localparam logic PAT_CHECKER = 1'b1;

    localparam int ENERGY_W = 16;
    localparam int MAGNET_W = 14;

    localparam logic [31:0] TH16_RESET = 32'd3721700;
    localparam logic [31:0] TH8_RESET  = 32'd126431000;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  site_row;
        logic [5:0]  site_col;
        logic [31:0] uniform_draw;
    } t_in_item;

    typedef struct packed {
        logic                       accepted;
        logic                       site_error;
        logic signed [ENERGY_W-1:0] energy_total;
        logic signed [MAGNET_W-1:0] magnetization_total;
    } t_out_item;

    typedef struct packed {
        logic [31:0] accept_threshold_16;
        logic [31:0] accept_threshold_8;
        logic        start_pattern;
    } t_cfg;

    typedef struct packed {
        logic                       accept;
        logic signed [ENERGY_W-1:0] energy_delta;
        logic signed [MAGNET_W-1:0] magnet_delta;
    } t_eval;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_INIT_DONE
    } t_state;

endpackage

// ----- hw/rtl/ising_metropolis_flip_top.sv -----
// ----------------------------------------------------------------------------
// ising_metropolis_flip_top: metropolis spin-flip engine for a 2d ising lattice
// periodic square lattice of one-bit spins with running energy and magnetization
// ----------------------------------------------------------------------------
// For a flip attempt, in the accept cycle the three row words around
// the site (its own row and the rows above and below) are read in one go from
// two row memories split by row parity, each L bits wide and L/2 rows deep; in
// the evaluate state (ST_EXEC) the neighbour test and threshold compare run and
// the updated row word is written back, so the next item already sees the new
// spin. An init item rewrites the lattice one row pair per cycle in ST_CLEAR,
// then posts its result from ST_INIT_DONE. After reset the same clearing pass
// loads the all-up lattice, with input ready low. A result sits in an output
// register; the next item is accepted while it waits, and that item holds in
// ST_EXEC only until the register is free. Sites with row or column at or above
// the lattice side give a site_error result and leave everything unchanged.
// ----------------------------------------------------------------------------
module ising_metropolis_flip_top
    import imf_pkg::*;
#(
    parameter int LATTICE_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // apb-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,

    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    // index width for rows and columns, row-pair address width
    localparam int IW = $clog2(LATTICE_SIDE);
    localparam int AW = $clog2(LATTICE_SIDE / 2);
    localparam int EW = IW + 6;

    localparam logic signed [ENERGY_W-1:0] ENERGY_UP =
        ENERGY_W'(-4 * LATTICE_SIDE * LATTICE_SIDE);
    localparam logic signed [MAGNET_W-1:0] MAGNET_UP =
        MAGNET_W'(LATTICE_SIDE * LATTICE_SIDE);

    // configuration
    t_cfg cfg;

    assign pready = 1'b1;

    imf_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // controller state
    t_state r_state, n_state;

    logic                       r_out_valid;
    t_out_item                  r_out;
    logic signed [ENERGY_W-1:0] r_energy;
    logic signed [MAGNET_W-1:0] r_magnet;
    logic [AW-1:0]              r_clr_row;
    logic                       r_clr_pattern;
    logic                       r_clr_report;

    // per-item payload, held through the evaluate cycle
    logic [IW-1:0] r_row;
    logic [IW-1:0] r_col;
    logic          r_err;
    logic [31:0]   r_draw;

    logic in_fire;
    logic in_ready;
    logic slot_free;
    logic exec_done;
    logic init_done;
    logic clr_we;
    logic clr_last;
    logic commit;

    assign in_fire   = i_in_valid & in_ready;
    assign slot_free = ~r_out_valid | i_out_ready;
    assign clr_last  = (r_clr_row == AW'(LATTICE_SIDE / 2 - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_report ? ST_INIT_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in_item.opcode == OP_INIT) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_INIT_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        exec_done = 1'b0;
        init_done = 1'b0;
        clr_we    = 1'b0;
        case (r_state)
            ST_CLEAR:     clr_we    = 1'b1;
            ST_IDLE:      in_ready  = 1'b1;
            ST_EXEC:      exec_done = slot_free;
            ST_INIT_DONE: init_done = slot_free;
            default: ;
        endcase
    end

    // site decode: range check on the raw fields, then wrap the neighbours
    logic [EW-1:0] row_ext;
    logic [EW-1:0] col_ext;
    logic          site_bad;
    logic [IW-1:0] row_idx;
    logic [IW-1:0] row_prev;
    logic [IW-1:0] row_next;

    always_comb begin
        row_ext  = EW'(i_in_item.site_row);
        col_ext  = EW'(i_in_item.site_col);
        site_bad = (row_ext >= EW'(LATTICE_SIDE)) | (col_ext >= EW'(LATTICE_SIDE));
        row_idx  = row_ext[IW-1:0];
        row_prev = (row_idx == '0) ? IW'(LATTICE_SIDE - 1) : row_idx - 1'b1;
        row_next = (row_idx == IW'(LATTICE_SIDE - 1)) ? '0 : row_idx + 1'b1;
    end

    // row memories: bank 0 holds even rows, bank 1 odd rows; with an even side
    // both vertical neighbours always sit in the bank opposite the site's row
    logic [AW-1:0]           raddr0_a, raddr1_a, raddr_b;
    logic [LATTICE_SIDE-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic                    we0, we1;
    logic [AW-1:0]           waddr;
    logic [LATTICE_SIDE-1:0] wdata;
    logic [LATTICE_SIDE-1:0] pat_row;
    logic [LATTICE_SIDE-1:0] new_row;

    always_comb begin
        raddr0_a = row_idx[0] ? row_prev[IW-1:1] : row_idx[IW-1:1];
        raddr1_a = row_idx[0] ? row_idx[IW-1:1]  : row_prev[IW-1:1];
        raddr_b  = row_next[IW-1:1];
    end

    // init pattern row: with an even side the checkerboard by linear index
    // reduces to odd columns up in every row
    always_comb begin
        for (int c = 0; c < LATTICE_SIDE; c++) begin
            pat_row[c] = (r_clr_pattern == PAT_CHECKER) ? c[0] : 1'b1;
        end
    end

    always_comb begin
        we0   = clr_we | (commit & ~r_row[0]);
        we1   = clr_we | (commit & r_row[0]);
        waddr = clr_we ? r_clr_row : r_row[IW-1:1];
        wdata = clr_we ? pat_row : new_row;
    end

    imf_row_bank #(
        .WIDTH (LATTICE_SIDE),
        .DEPTH (LATTICE_SIDE / 2)
    ) u_bank_even (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (in_fire),
        .i_raddr_a (raddr0_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    imf_row_bank #(
        .WIDTH (LATTICE_SIDE),
        .DEPTH (LATTICE_SIDE / 2)
    ) u_bank_odd (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (in_fire),
        .i_raddr_a (raddr1_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    // evaluate cycle: steer the bank outputs back to site-relative rows
    logic [LATTICE_SIDE-1:0] cur_row;
    logic [LATTICE_SIDE-1:0] prev_row;
    logic [LATTICE_SIDE-1:0] next_row;
    t_eval                   eval;

    assign cur_row  = r_row[0] ? rd1_a : rd0_a;
    assign prev_row = r_row[0] ? rd0_a : rd1_a;
    assign next_row = r_row[0] ? rd0_b : rd1_b;

    imf_spin_eval #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_eval (
        .i_cur_row  (cur_row),
        .i_prev_row (prev_row),
        .i_next_row (next_row),
        .i_col      (r_col),
        .i_draw     (r_draw),
        .i_cfg      (cfg),
        .o_eval     (eval),
        .o_new_row  (new_row)
    );

    assign commit = exec_done & ~r_err & eval.accept;

    // totals after this item
    logic signed [ENERGY_W-1:0] n_energy;
    logic signed [MAGNET_W-1:0] n_magnet;

    always_comb begin
        n_energy = r_energy;
        n_magnet = r_magnet;
        if (commit) begin
            n_energy = r_energy + eval.energy_delta;
            n_magnet = r_magnet + eval.magnet_delta;
        end else if (init_done) begin
            n_energy = (r_clr_pattern == PAT_CHECKER) ? '0 : ENERGY_UP;
            n_magnet = (r_clr_pattern == PAT_CHECKER) ? '0 : MAGNET_UP;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_out_valid   <= 1'b0;
            r_energy      <= ENERGY_UP;
            r_magnet      <= MAGNET_UP;
            r_clr_row     <= '0;
            r_clr_pattern <= PAT_ALL_UP;
            r_clr_report  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_energy <= n_energy;
            r_magnet <= n_magnet;
            if (exec_done | init_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire && i_in_item.opcode == OP_INIT) begin
                r_clr_row     <= '0;
                r_clr_pattern <= cfg.start_pattern;
                r_clr_report  <= 1'b1;
            end else if (clr_we) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_row  <= row_idx;
            r_col  <= col_ext[IW-1:0];
            r_err  <= site_bad;
            r_draw <= i_in_item.uniform_draw;
        end
        if (exec_done | init_done) begin
            r_out.accepted            <= commit;
            r_out.site_error          <= exec_done & r_err;
            r_out.energy_total        <= n_energy;
            r_out.magnetization_total <= n_magnet;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- hw/rtl/imf_row_bank.sv -----
// ----------------------------------------------------------------------------
// imf_row_bank: lattice row memory
// one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module imf_row_bank #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

// ----- hw/rtl/imf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// imf_cfg_regs: configuration register file
// acceptance thresholds and start pattern behind an apb-style port
// ----------------------------------------------------------------------------
module imf_cfg_regs
    import imf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accept_threshold_16 <= TH16_RESET;
            r_cfg.accept_threshold_8  <= TH8_RESET;
            r_cfg.start_pattern       <= PAT_ALL_UP;
        end else if (wr_en) begin
            case (i_paddr[3:2])
                REG_TH16:    r_cfg.accept_threshold_16 <= i_pwdata;
                REG_TH8:     r_cfg.accept_threshold_8  <= i_pwdata;
                REG_PATTERN: r_cfg.start_pattern       <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_TH16:    o_prdata = r_cfg.accept_threshold_16;
            REG_TH8:     o_prdata = r_cfg.accept_threshold_8;
            REG_PATTERN: o_prdata = {31'd0, r_cfg.start_pattern};
            default:     o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/imf_spin_eval.sv -----
// ----------------------------------------------------------------------------
// imf_spin_eval: metropolis decision for one site
// neighbour match count, energy step, threshold test and flipped row word
// ----------------------------------------------------------------------------
module imf_spin_eval
    import imf_pkg::*;
#(
    parameter int LATTICE_SIDE = 64
) (
    input  logic [LATTICE_SIDE-1:0]         i_cur_row,
    input  logic [LATTICE_SIDE-1:0]         i_prev_row,
    input  logic [LATTICE_SIDE-1:0]         i_next_row,
    input  logic [$clog2(LATTICE_SIDE)-1:0] i_col,
    input  logic [31:0]                     i_draw,
    input  t_cfg                            i_cfg,
    output t_eval                           o_eval,
    output logic [LATTICE_SIDE-1:0]         o_new_row
);

    localparam int IW = $clog2(LATTICE_SIDE);

    logic [IW-1:0] col_p;
    logic [IW-1:0] col_m;
    logic          spin;
    logic [3:0]    nb;
    logic [3:0]    same;
    logic [2:0]    match_cnt;

    always_comb begin
        col_p = (i_col == IW'(LATTICE_SIDE - 1)) ? '0 : i_col + 1'b1;
        col_m = (i_col == '0) ? IW'(LATTICE_SIDE - 1) : i_col - 1'b1;
        spin  = i_cur_row[i_col];
        nb    = {i_prev_row[i_col], i_next_row[i_col], i_cur_row[col_p], i_cur_row[col_m]};
        // neighbours aligned with the site raise the energy cost of a flip
        same  = spin ? nb : ~nb;
        match_cnt = {2'b00, same[0]} + {2'b00, same[1]} + {2'b00, same[2]}
                  + {2'b00, same[3]};
    end

    always_comb begin
        // delta e = 8 * matches - 16
        o_eval.energy_delta = {10'd0, match_cnt, 3'd0} - 16'sd16;
        o_eval.magnet_delta = spin ? 14'h3ffe : 14'h0002;
        if (match_cnt == 3'd4) begin
            o_eval.accept = i_draw < i_cfg.accept_threshold_16;
        end else if (match_cnt == 3'd3) begin
            o_eval.accept = i_draw < i_cfg.accept_threshold_8;
        end else begin
            o_eval.accept = 1'b1;
        end
    end

    always_comb begin
        o_new_row        = i_cur_row;
        o_new_row[i_col] = ~spin;
    end

endmodule

// ----- verif/ising_metropolis_flip_top_test.sv -----
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// ising_metropolis_flip_top_test: self-checking bench for the ising flip engine
// sends flip and init items with random gaps and output stalls, keeps its own
// copy of the lattice and totals, and checks every result item field by field
// ----------------------------------------------------------------------------
module ising_metropolis_flip_top_test;
    import imf_pkg::*;

    localparam int SIDE = 64;
    localparam int SITES = SIDE * SIDE;
    localparam int MAX_REPORTS = 10;
    localparam int MAX_GAP = 10;
    // settle time covers an init pass with some margin past it
    localparam int SETTLE_CYCLES = SIDE / 2 + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    // clock, reset and configuration port
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // item channels
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;

    // local copy of the lattice, totals and registers
    bit                         lattice [SITES];
    logic signed [ENERGY_W-1:0] energy_now;
    logic signed [MAGNET_W-1:0] magnet_now;
    logic [31:0]                th16_now;
    logic [31:0]                th8_now;
    logic                       pattern_now;

    // result items still owed by the block, oldest first
    t_out_item expected_updates [$];

    // idling controls: the sender's is read only by the main process, the
    // receiver's are written with nonblocking assignments at the clock edge
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit rx_hold = 1'b0;
    int rx_stall = 0;

    // where the focused part of the random flips lands in the current phase
    int focus_row = 0;
    int focus_col = 0;

    // bookkeeping for the run summary
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int init_count = 0;
    int flips_taken = 0;
    int flips_refused = 0;
    int settings_applied = 0;
    int de_class_count [5] = '{default: 0};

    ising_metropolis_flip_top #(
        .LATTICE_SIDE(SIDE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #RUN_LIMIT_NS;
        $display("run stopped after %0d ns with %0d results still owed",
                 RUN_LIMIT_NS, expected_updates.size());
        $display("ising_metropolis_flip_top_test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // lattice predictor
    // ------------------------------------------------------------------------

    // rewrite the whole lattice and both totals as an init item does
    function automatic void load_lattice(logic pat);
        for (int k = 0; k < SITES; k++) begin
            lattice[k] = (pat == PAT_CHECKER) ? bit'(k & 1) : 1'b1;
        end
        if (pat == PAT_CHECKER) begin
            energy_now = '0;
            magnet_now = '0;
        end else begin
            energy_now = ENERGY_W'(-4 * SITES);
            magnet_now = MAGNET_W'(SITES);
        end
    endfunction

    function automatic int spin_val(int r, int c);
        return lattice[r * SIDE + c] ? 1 : -1;
    endfunction

    // apply one item to the local lattice and return the result it must give
    function automatic t_out_item predict_update(t_in_item it);
        t_out_item res;
        int        r;
        int        c;
        int        nn;
        int        s;
        int        de;
        bit        take;
        res = '0;
        if (it.opcode == OP_INIT) begin
            load_lattice(pattern_now);
            init_count++;
        end else if (it.site_row >= SIDE || it.site_col >= SIDE) begin
            res.site_error = 1'b1;
        end else begin
            r = it.site_row;
            c = it.site_col;
            // four neighbours with periodic wrap
            nn = spin_val((r + 1) % SIDE, c) + spin_val((r + SIDE - 1) % SIDE, c)
               + spin_val(r, (c + 1) % SIDE) + spin_val(r, (c + SIDE - 1) % SIDE);
            s = spin_val(r, c);
            de = 4 * s * nn;
            de_class_count[(de + 16) / 8]++;
            // uphill moves go through the threshold, everything else flips
            if (de == 16) begin
                take = it.uniform_draw < th16_now;
            end else if (de == 8) begin
                take = it.uniform_draw < th8_now;
            end else begin
                take = 1'b1;
            end
            if (take) begin
                lattice[r * SIDE + c] = ~lattice[r * SIDE + c];
                energy_now = energy_now + ENERGY_W'(de);
                magnet_now = magnet_now - MAGNET_W'(2 * s);
                res.accepted = 1'b1;
                flips_taken++;
            end else begin
                flips_refused++;
            end
        end
        res.energy_total = energy_now;
        res.magnetization_total = magnet_now;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (expected_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: result with nothing owed: acc=%0b err=%0b e=%0d m=%0d",
                         $realtime, got.accepted, got.site_error, got.energy_total,
                         got.magnetization_total);
            end
            return;
        end
        want = expected_updates.pop_front();
        results_checked++;
        if (got.accepted !== want.accepted || got.site_error !== want.site_error
                || got.energy_total !== want.energy_total
                || got.magnetization_total !== want.magnetization_total) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: result %0d mismatch: acc %0b/%0b err %0b/%0b e %0d/%0d m %0d/%0d",
                         $realtime, results_checked, want.accepted, got.accepted,
                         want.site_error, got.site_error, want.energy_total,
                         got.energy_total, want.magnetization_total,
                         got.magnetization_total);
            end
        end
    endfunction

    // receiver: random stall after each result while rx_idle is set, plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                check_result(out_item);
                rx_stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            out_ready <= (rx_stall == 0) && !rx_hold;
        end
    end

    // ------------------------------------------------------------------------
    // sender and configuration helpers
    // ------------------------------------------------------------------------

    // valid only drops when a gap is drawn, so back-to-back items keep it high
    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (!in_ready);
        expected_updates.push_back(predict_update(it));
        items_sent++;
    endtask

    // stop offering items and wait until every owed result is back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TH16: th16_now = value;
            REG_TH8:  th8_now = value;
            default:  pattern_now = value[0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: register %0d reads %h, expected %h", $realtime, idx, got, want);
            end
        end
    endtask

    // new register setting, applied only once the block has gone quiet
    task automatic apply_settings(input logic [31:0] t16, input logic [31:0] t8,
                                  input logic pat);
        wait_results_drained();
        write_reg(REG_TH16, t16);
        write_reg(REG_TH8, t8);
        write_reg(REG_PATTERN, {31'd0, pat});
        check_reg(REG_TH16, t16);
        check_reg(REG_TH8, t8);
        check_reg(REG_PATTERN, {31'd0, pat});
        settings_applied++;
    endtask

    function automatic t_in_item flip_at(int r, int c, logic [31:0] draw);
        t_in_item it;
        it.opcode = OP_FLIP;
        it.site_row = 6'(r);
        it.site_col = 6'(c);
        it.uniform_draw = draw;
        return it;
    endfunction

    // site and draw fields of an init item are don't-care, so fill them randomly
    function automatic t_in_item init_item();
        t_in_item it;
        it.opcode = OP_INIT;
        it.site_row = 6'($urandom_range(0, 63));
        it.site_col = 6'($urandom_range(0, 63));
        it.uniform_draw = $urandom();
        return it;
    endfunction

    // mostly a small patch around the focus so flips interact, draws often
    // sitting right on a threshold
    function automatic t_in_item random_flip();
        int          r;
        int          c;
        logic [31:0] draw;
        if ($urandom_range(0, 9) < 6) begin
            r = (focus_row + $urandom_range(0, 3)) % SIDE;
            c = (focus_col + $urandom_range(0, 3)) % SIDE;
        end else begin
            r = $urandom_range(0, SIDE - 1);
            c = $urandom_range(0, SIDE - 1);
        end
        case ($urandom_range(0, 3))
            0:       draw = th8_now + $urandom_range(0, 4) - 2;
            1:       draw = th16_now + $urandom_range(0, 4) - 2;
            default: draw = $urandom();
        endcase
        return flip_at(r, c, draw);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers come up with their documented reset values
    task automatic test_reset_values();
        check_reg(REG_TH16, TH16_RESET);
        check_reg(REG_TH8, TH8_RESET);
        check_reg(REG_PATTERN, {31'd0, PAT_ALL_UP});
    endtask

    // from the all-up lattice: uphill moves at and around the thresholds,
    // downhill moves, wrap at the lattice corners
    task automatic test_uphill_moves();
        send_item(flip_at(0, 0, 32'd0));
        send_item(flip_at(0, 1, TH8_RESET));
        send_item(flip_at(0, 1, TH8_RESET - 1));
        send_item(flip_at(0, 0, 32'hFFFF_FFFF));
        send_item(flip_at(SIDE - 1, SIDE - 1, TH16_RESET));
        send_item(flip_at(SIDE - 1, SIDE - 1, TH16_RESET - 1));
        send_item(flip_at(SIDE - 1, 0, 32'hFFFF_FFFF));
        send_item(init_item());
    endtask

    // thresholds at zero refuse every uphill move, at all ones accept all
    // but the largest draw
    task automatic test_threshold_extremes();
        apply_settings(32'd0, 32'd0, PAT_ALL_UP);
        send_item(flip_at(10, 10, 32'd0));
        send_item(flip_at(20, 33, 32'd0));
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, PAT_ALL_UP);
        send_item(flip_at(10, 10, 32'hFFFF_FFFE));
        send_item(flip_at(10, 11, 32'hFFFF_FFFF));
    endtask

    // alternating start: flips at the four corners and at the neighbours of the
    // (0,0) corner
    task automatic test_alternating_start();
        t_in_item it;
        apply_settings(TH16_RESET, TH8_RESET, PAT_CHECKER);
        it = init_item();
        it.site_row = 6'h3F;
        it.site_col = 6'h3F;
        it.uniform_draw = 32'hFFFF_FFFF;
        send_item(it);
        send_item(flip_at(0, 0, 32'hFFFF_FFFF));
        send_item(flip_at(SIDE - 1, SIDE - 1, 32'd0));
        send_item(flip_at(0, SIDE - 1, 32'd0));
        send_item(flip_at(SIDE - 1, 0, 32'd0));
        send_item(flip_at(0, 1, 32'd0));
        send_item(flip_at(1, 0, 32'd0));
        send_item(flip_at(1, 1, 32'd0));
    endtask

    // receiver holds off for a long stretch while the sender keeps pushing,
    // so the result register fills and input ready has to drop
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            for (int n = 0; n < 24; n++) send_item(random_flip());
        join
        tx_idle = 1'b1;
        wait_results_drained();
    endtask

    // random phases cycling through threshold extremes, both start patterns
    // and every mix of sender and receiver idling
    task automatic test_random_traffic();
        int sel;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0:       apply_settings(TH16_RESET, TH8_RESET, PAT_ALL_UP);
                1:       apply_settings(32'd0, 32'd0, PAT_CHECKER);
                2:       apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, PAT_ALL_UP);
                default: apply_settings($urandom(), $urandom(), PAT_CHECKER);
            endcase
            sel = (phase / 2) % 4;
            tx_idle = (sel == 0 || sel == 1);
            rx_idle <= (sel == 0 || sel == 2);
            // first phase sits across the wrap corner
            focus_row = (phase == 0) ? SIDE - 2 : $urandom_range(0, SIDE - 1);
            focus_col = (phase == 0) ? SIDE - 2 : $urandom_range(0, SIDE - 1);
            send_item(init_item());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 49) == 0) begin
                    send_item(init_item());
                end else begin
                    send_item(random_flip());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        th16_now = TH16_RESET;
        th8_now = TH8_RESET;
        pattern_now = PAT_ALL_UP;
        load_lattice(PAT_ALL_UP);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // block runs its clearing pass with input ready low
        do @(posedge i_clk); while (!in_ready);

        test_reset_values();
        test_uphill_moves();
        test_threshold_extremes();
        test_alternating_start();
        test_output_backpressure();
        test_random_traffic();
        wait_results_drained();

        $display("covered %0d items (%0d inits), %0d flips taken, %0d refused, %0d settings",
                 items_sent, init_count, flips_taken, flips_refused, settings_applied);
        $display("energy steps -16/-8/0/+8/+16 seen %0d/%0d/%0d/%0d/%0d times, %0d mismatches",
                 de_class_count[0], de_class_count[1], de_class_count[2],
                 de_class_count[3], de_class_count[4], mismatches);
        if (mismatches == 0 && expected_updates.size() == 0) begin
            $display("ising_metropolis_flip_top_test passed");
        end else begin
            $display("ising_metropolis_flip_top_test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/imf_pkg.sv
hw/rtl/imf_row_bank.sv
hw/rtl/imf_cfg_regs.sv
hw/rtl/imf_spin_eval.sv
hw/rtl/ising_metropolis_flip_top.sv
verif/ising_metropolis_flip_top_test.sv
